[hw/rtl/fbfl_pkg.sv]
// shared types and constants of the fixed block free list allocator
package fbfl_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_BAD_REQ = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // configuration register indexes
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_ALIGN = 1'b1;

  // floors that keep room for the 8-byte link
  localparam logic [15:0] MIN_BLOCK = 16'd8;
  localparam logic [3:0]  MIN_ALIGN = 4'd3;

  // saturation point of the added-blocks count
  localparam logic [8:0] ADDED_MAX = 9'h1FF;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // word accepted, capture fields
    logic pop;         // pop the top of the stack
    logic push_in;     // push the incoming address
    logic carve_push;  // push the current carved block
    logic carve_end;   // carving finished
    logic out_load;    // move the result into the output register
  } fbfl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic alloc_ok;    // allocate on the input would succeed
    logic full;        // stack full
    logic fit;         // current carved block lies inside the region
  } fbfl_stat_t;

endpackage

[hw/rtl/fbfl_ctrl.sv]
// control state machine of the fixed block free list allocator
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] cmd,
  input  logic       out_stall,
  input  fbfl_stat_t st,
  output fbfl_cmd_t  c,
  output logic       in_stall,
  output logic       out_valid
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CARVE  = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       accept;
  logic       slot_free;

  assign accept    = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    c            = '0;
    c.load       = accept;
    c.pop        = accept && (cmd == CMD_ALLOC) && st.alloc_ok;
    c.push_in    = accept && (cmd == CMD_FREE) && !st.full;
    c.carve_push = (state == S_CARVE) && st.fit && !st.full;
    c.carve_end  = (state == S_CARVE) && (!st.fit || st.full);
    c.out_load   = (state == S_RESULT) && slot_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd == CMD_ADD) ? S_CARVE : S_RESULT;
        end
      end
      S_CARVE: begin
        if (c.carve_end) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (c.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (c.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hw/rtl/fbfl_dpath.sv]
// datapath of the fixed block free list allocator: stack memory, carver, result registers
module fbfl_dpath
  import fbfl_pkg::*;
#(
  parameter int FREE_SLOTS = 256,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  fbfl_cmd_t   c,
  input  logic [1:0]  cmd,
  input  logic [15:0] req_size,
  input  logic [3:0]  req_align_log2,
  input  logic [31:0] address,
  input  logic [31:0] region_length,
  input  logic [15:0] block_size,
  input  logic [3:0]  block_align_log2,
  output fbfl_stat_t  st,
  output logic        ok,
  output logic [31:0] block_address,
  output logic [1:0]  status,
  output logic [8:0]  blocks_added
);

  localparam int CNT_W   = $clog2(FREE_SLOTS + 1);
  localparam int IDX_W   = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int STORE_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  logic [STORE_W-1:0] mem [FREE_SLOTS];
  logic [STORE_W-1:0] rd_data;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_m1;

  logic [15:0] eff_bs;
  logic [3:0]  eff_al;
  logic [15:0] al_m1;
  logic [16:0] stride;
  logic        empty;
  logic        full;
  logic        req_bad;

  logic [33:0] cur;
  logic [32:0] end_addr;
  logic [16:0] stride_r;
  logic [1:0]  res_status;
  logic        res_pop;
  logic [8:0]  added;

  assign eff_bs   = (block_size < MIN_BLOCK) ? MIN_BLOCK : block_size;
  assign eff_al   = (block_align_log2 < MIN_ALIGN) ? MIN_ALIGN : block_align_log2;
  assign al_m1    = 16'((17'd1 << eff_al) - 17'd1);
  assign stride   = (17'(eff_bs) + 17'(al_m1)) & ~17'(al_m1);
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(FREE_SLOTS));
  assign count_m1 = count - CNT_W'(1);
  // a raised request of 8 never beats the raised block size, so compare raw
  assign req_bad  = (req_size > eff_bs) || (req_align_log2 > eff_al);

  always_comb begin
    st          = '0;
    st.alloc_ok = !empty && !req_bad;
    st.full     = full;
    st.fit      = ({1'b0, cur} + 35'(eff_bs)) <= {2'b00, end_addr};
  end

  // stack memory, one access per cycle
  always_ff @(posedge clk) begin
    if (c.push_in) begin
      mem[count[IDX_W-1:0]] <= address[STORE_W-1:0];
    end else if (c.carve_push) begin
      mem[count[IDX_W-1:0]] <= cur[STORE_W-1:0];
    end
    if (c.pop) begin
      rd_data <= mem[count_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (c.pop) begin
      count <= count_m1;
    end else if (c.push_in || c.carve_push) begin
      count <= count + CNT_W'(1);
    end
  end

  // carving walker and pending result
  always_ff @(posedge clk) begin
    if (c.load) begin
      end_addr <= {1'b0, address} + {1'b0, region_length};
      cur      <= 34'(({1'b0, address} + 33'(al_m1)) & ~33'(al_m1));
      stride_r <= stride;
      res_pop  <= (cmd == CMD_ALLOC) && !empty && !req_bad;
      added    <= ((cmd == CMD_FREE) && !full) ? 9'd1 : 9'd0;
      case (cmd)
        CMD_ALLOC: begin
          res_status <= empty ? ST_EMPTY : (req_bad ? ST_BAD_REQ : ST_OK);
        end
        CMD_FREE: begin
          res_status <= full ? ST_FULL : ST_OK;
        end
        CMD_ADD: begin
          res_status <= ST_OK;
        end
        default: begin
          res_status <= ST_BAD_REQ;
        end
      endcase
    end else if (c.carve_push) begin
      cur <= cur + 34'(stride_r);
      if (added != ADDED_MAX) begin
        added <= added + 9'd1;
      end
    end else if (c.carve_end) begin
      // a block that fits but finds the stack full is dropped
      if (st.fit && full) begin
        res_status <= ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c.out_load) begin
      ok            <= (res_status == ST_OK);
      status        <= res_status;
      blocks_added  <= added;
      block_address <= res_pop ? 32'(rd_data) : 32'd0;
    end
  end

endmodule

[hw/rtl/fixed_block_free_list_allocator.sv]
// top level of the fixed block free list allocator: config registers, controller, datapath
//
//  channel  dir  handshake                 payload
//  in       in   in_valid / in_stall       cmd, req_size, req_align_log2, address,
//                                          region_length
//  out      out  out_valid / out_stall     ok, block_address, status, blocks_added
//  config   in   psel/penable/pwrite/...   block_size (0x0), block_align_log2 (0x4)
//
// allocate, free and unknown commands do the stack pop or push on the accept edge;
//   the result state then loads the output register once it is free
// add-region pushes its carved blocks one block per cycle, bound by the single
//   write port of the stack memory
// a new word is accepted while the previous result still waits under out_stall;
//   the block holds its next result until the output register is free
// synchronous reset empties the stack at once; the stack memory itself is not
//   cleared, only entries below the fill count are ever read
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int FREE_SLOTS = 256,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] req_size,
  input  logic [3:0]  req_align_log2,
  input  logic [31:0] address,
  input  logic [31:0] region_length,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [31:0] block_address,
  output logic [1:0]  status,
  output logic [8:0]  blocks_added,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fbfl_cmd_t  c;
  fbfl_stat_t st;

  logic [15:0] block_size;
  logic [3:0]  block_align_log2;
  logic        cfg_write;

  // configuration registers, zero-wait port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size       <= 16'd8;
      block_align_log2 <= 4'd3;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_BLOCK_SIZE:  block_size       <= pwdata[15:0];
        REG_BLOCK_ALIGN: block_align_log2 <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BLOCK_SIZE:  prdata = {16'd0, block_size};
      REG_BLOCK_ALIGN: prdata = {28'd0, block_align_log2};
      default:         prdata = 32'd0;
    endcase
  end

  // sequencing of accept, pop/push, carving and result hand-off
  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .out_stall (out_stall),
    .st        (st),
    .c         (c),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // stack memory, fill count, region carver and output register
  fbfl_dpath #(
    .FREE_SLOTS (FREE_SLOTS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .c                (c),
    .cmd              (cmd),
    .req_size         (req_size),
    .req_align_log2   (req_align_log2),
    .address          (address),
    .region_length    (region_length),
    .block_size       (block_size),
    .block_align_log2 (block_align_log2),
    .st               (st),
    .ok               (ok),
    .block_address    (block_address),
    .status           (status),
    .blocks_added     (blocks_added)
  );

  // one word in flight: an accepted word closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // ok flag agrees with the status code
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (status == ST_OK)))
    else $error("ok flag and status disagree");

  // a nonzero block address only comes with a successful allocate
  a_addr_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (block_address != 32'd0)) |-> (ok && (blocks_added == 9'd0)))
    else $error("block address on a result that is not an allocate");

  // the stack never pops and pushes in the same cycle
  a_no_pop_push: assert property (@(posedge clk) disable iff (rst)
    !(c.pop && (c.push_in || c.carve_push)))
    else $error("stack pop and push at once");

endmodule

[tb/fixed_block_free_list_allocator_test.sv]
`timescale 1ns / 100ps
// self-checking testbench of the fixed block free list allocator
module fixed_block_free_list_allocator_test;
  import fbfl_pkg::*;

  localparam int POOL_SLOTS = 256;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 240;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 100;

  // one input word and one result word, at the port widths
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] size;
    logic [3:0]  align;
    logic [31:0] addr;
    logic [31:0] len;
  } word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
    logic [1:0]  status;
    logic [8:0]  added;
  } result_t;

  // a directed row: the word, and a hand-written answer where it is obvious
  typedef struct packed {
    word_t   w;
    logic    typed;
    result_t res;
  } row_t;

  localparam result_t NO_RES    = '0;
  localparam result_t EMPTY_RES = '{1'b0, 32'd0, ST_EMPTY, 9'd0};
  localparam result_t BAD_RES   = '{1'b0, 32'd0, ST_BAD_REQ, 9'd0};
  localparam result_t FULL_RES  = '{1'b0, 32'd0, ST_FULL, 9'd0};
  localparam result_t ONE_RES   = '{1'b1, 32'd0, ST_OK, 9'd1};
  localparam result_t NONE_RES  = '{1'b1, 32'd0, ST_OK, 9'd0};

  // per phase: register settings and how often each side idles
  localparam logic [15:0] PHASE_BLOCK [PHASES] = '{16'd8, 16'd0, 16'd65535, 16'd24,
                                                   16'd7, 16'd100, 16'd65535, 16'd16};
  localparam logic [3:0]  PHASE_ALIGN [PHASES] = '{4'd3, 4'd0, 4'd12, 4'd4,
                                                   4'd2, 4'd5, 4'd15, 4'd3};
  localparam int PHASE_SEND_IDLE [PHASES] = '{0, 70, 0, 31, 0, 70, 0, 31};
  localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 70, 31, 0, 0, 70, 31};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [15:0] req_size;
  logic [3:0]  req_align_log2;
  logic [31:0] address;
  logic [31:0] region_length;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [31:0] block_address;
  logic [1:0]  status;
  logic [8:0]  blocks_added;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fixed_block_free_list_allocator dut (.*);

  // predictor copy of the pool and the registers
  logic [31:0] pool_stack [POOL_SLOTS];
  int unsigned pool_fill = 0;
  logic [15:0] cfg_block = 16'd8;
  logic [3:0]  cfg_align = 4'd3;

  result_t due_results [$];   // results still owed by the block, oldest first
  row_t    offered_words [$]; // words put on the input, not yet accepted

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int errors = 0;
  int n_alloc = 0, n_granted = 0, n_free = 0, n_regions = 0, n_carved = 0;
  int n_full = 0, n_bad = 0;

  // directed words, run with the registers at their reset values (8 bytes, 8-byte align)
  row_t directed_plan [19] = '{
    // empty pool, smallest and largest requests
    '{'{CMD_ALLOC, 16'd0, 4'd0, 32'd0, 32'd0}, 1'b1, EMPTY_RES},
    // empty wins over an oversized, over-aligned request
    '{'{CMD_ALLOC, 16'hFFFF, 4'hF, 32'd0, 32'd0}, 1'b1, EMPTY_RES},
    '{'{CMD_UNKNOWN, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, BAD_RES},
    '{'{CMD_FREE, 16'd0, 4'd0, 32'hFFFF_FFF8, 32'd0}, 1'b1, ONE_RES},
    '{'{CMD_ALLOC, 16'd9, 4'd0, 32'd0, 32'd0}, 1'b1, BAD_RES},
    '{'{CMD_ALLOC, 16'd8, 4'd4, 32'd0, 32'd0}, 1'b1, BAD_RES},
    '{'{CMD_ALLOC, 16'd0, 4'd3, 32'd0, 32'd0}, 1'b1, '{1'b1, 32'hFFFF_FFF8, ST_OK, 9'd0}},
    // regions too short to hold a block
    '{'{CMD_ADD, 16'd0, 4'd0, 32'd0, 32'd0}, 1'b1, NONE_RES},
    '{'{CMD_ADD, 16'd0, 4'd0, 32'd1, 32'd7}, 1'b0, NO_RES},
    // unaligned start gets rounded up
    '{'{CMD_ADD, 16'd0, 4'd0, 32'd5, 32'd64}, 1'b0, NO_RES},
    '{'{CMD_ALLOC, 16'd8, 4'd3, 32'd0, 32'd0}, 1'b0, NO_RES},
    '{'{CMD_ALLOC, 16'd8, 4'd0, 32'd0, 32'd0}, 1'b0, NO_RES},
    // region running past the top of the address space, addresses wrap
    '{'{CMD_ADD, 16'd0, 4'd0, 32'hFFFF_FFF0, 32'h40}, 1'b0, NO_RES},
    // huge region overflows the store
    '{'{CMD_ADD, 16'd0, 4'd0, 32'd0, 32'hFFFF_FFFF}, 1'b0, NO_RES},
    '{'{CMD_FREE, 16'd0, 4'd0, 32'h1234_5678, 32'd0}, 1'b1, FULL_RES},
    '{'{CMD_ALLOC, 16'hFFFF, 4'd0, 32'd0, 32'd0}, 1'b1, BAD_RES},
    '{'{CMD_ALLOC, 16'd8, 4'd3, 32'd0, 32'd0}, 1'b0, NO_RES},
    '{'{CMD_FREE, 16'd0, 4'd0, 32'd0, 32'd0}, 1'b0, NO_RES},
    '{'{CMD_ADD, 16'd0, 4'd0, 32'h100, 32'h100}, 1'b1, FULL_RES}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // effective block geometry: floors keep room for the 8-byte link
  function automatic logic [63:0] eff_block();
    return (cfg_block < MIN_BLOCK) ? 64'(MIN_BLOCK) : 64'(cfg_block);
  endfunction

  function automatic logic [3:0] eff_align();
    return (cfg_align < MIN_ALIGN) ? MIN_ALIGN : cfg_align;
  endfunction

  function automatic logic [63:0] carve_stride();
    logic [63:0] al;
    al = 64'd1 << eff_align();
    return (eff_block() + al - 1) & ~(al - 1);
  endfunction

  function automatic bit pool_push(logic [63:0] a);
    if (pool_fill >= POOL_SLOTS) return 1'b0;
    pool_stack[pool_fill] = a[31:0];
    pool_fill++;
    return 1'b1;
  endfunction

  // result of one word against the predictor pool; updates the pool
  function automatic result_t pool_next_result(word_t w);
    result_t r;
    logic [63:0] need, al, stride, region_end, first_blk, n, i;
    bit dropped;
    r = '0;
    case (w.op)
      CMD_ALLOC: begin
        need = (w.size < MIN_BLOCK) ? 64'(MIN_BLOCK) : 64'(w.size);
        // empty store is reported ahead of a bad request
        if (pool_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (need > eff_block() || w.align > eff_align()) begin
          r.status = ST_BAD_REQ;
        end else begin
          pool_fill--;
          r.ok = 1'b1;
          r.addr = pool_stack[pool_fill];
          r.status = ST_OK;
        end
      end
      CMD_FREE: begin
        if (pool_push(64'(w.addr))) begin
          r.ok = 1'b1;
          r.added = 9'd1;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_ADD: begin
        al = 64'd1 << eff_align();
        stride = carve_stride();
        region_end = 64'(w.addr) + 64'(w.len);
        first_blk = (64'(w.addr) + al - 1) & ~(al - 1);
        n = 0;
        if (first_blk <= region_end && region_end - first_blk >= eff_block())
          n = (region_end - first_blk - eff_block()) / stride + 1;
        // ascending pushes, stop at the first one that finds the store full
        dropped = 1'b0;
        for (i = 0; i < n && !dropped; i++) begin
          if (!pool_push(first_blk + i * stride)) dropped = 1'b1;
          else if (r.added != ADDED_MAX) r.added = r.added + 9'd1;
        end
        r.ok = !dropped;
        r.status = dropped ? ST_FULL : ST_OK;
      end
      default: begin
        r.status = ST_BAD_REQ;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // random word: mostly well-formed for the current geometry, some pure noise
  function automatic word_t random_word();
    word_t w;
    logic [63:0] stride;
    int alloc_pct, pick;
    w.op = 2'($urandom_range(3, 0));
    w.size = 16'($urandom);
    w.align = 4'($urandom);
    w.addr = $urandom;
    w.len = $urandom;
    if ($urandom_range(99) < 8) return w;
    stride = carve_stride();
    // steer the fill level so both the empty and the full store come up
    alloc_pct = (pool_fill > 200) ? 75 : (pool_fill < 8) ? 20 : 45;
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      w.op = CMD_ALLOC;
      if ($urandom_range(9) != 0) w.size = 16'($urandom_range(32'(eff_block()), 0));
      if ($urandom_range(9) != 0) w.align = 4'($urandom_range(32'(eff_align()), 0));
    end else if (pick < alloc_pct + (100 - alloc_pct) * 2 / 3) begin
      w.op = CMD_FREE;
      w.addr = w.addr & ~(32'(64'd1 << eff_align()) - 32'd1);
    end else begin
      w.op = CMD_ADD;
      // a handful of blocks plus a ragged tail; now and then a huge region
      if ($urandom_range(19) != 0)
        w.len = 32'(stride * $urandom_range(6) + $urandom_range(32'(stride)));
    end
    return w;
  endfunction

  // scoreboard: results are checked before the same edge's accepted word is predicted
  always @(posedge clk) begin
    result_t got, want, calc;
    row_t info;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{ok, block_address, status, blocks_added};
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t ns: result word with nothing expected, got %p", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("block_address", want.addr, got.addr);
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("blocks_added", 32'(want.added), 32'(got.added));
        end
      end
      if (in_valid && !in_stall) begin
        info = offered_words.pop_front();
        calc = pool_next_result('{cmd, req_size, req_align_log2, address, region_length});
        want = info.typed ? info.res : calc;
        due_results.push_back(want);
        case (cmd)
          CMD_ALLOC: begin
            n_alloc++;
            if (want.ok) n_granted++;
          end
          CMD_FREE: n_free++;
          CMD_ADD: begin
            n_regions++;
            n_carved += want.added;
          end
          default: ;
        endcase
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_BAD_REQ) n_bad++;
      end
    end
  end

  // result side: random stalls, plus a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one word after a random gap and hold it until accepted
  task automatic drive_word(word_t w, logic typed, result_t res);
    row_t info;
    info = '{w, typed, res};
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    offered_words.push_back(info);
    in_valid <= 1'b1;
    cmd <= w.op;
    req_size <= w.size;
    req_align_log2 <= w.align;
    address <= w.addr;
    region_length <= w.len;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write (setup + access), then read it back
  task automatic write_reg(logic idx, logic [31:0] value);
    logic [31:0] seen;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_BLOCK_SIZE) begin
      check_field("block_size readback", value, {16'd0, seen[15:0]});
      cfg_block = value[15:0];
    end else begin
      check_field("block_align_log2 readback", value, {28'd0, seen[3:0]});
      cfg_align = value[3:0];
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_ALLOC;
    req_size = '0;
    req_align_log2 = '0;
    address = '0;
    region_length = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at the reset geometry
    foreach (directed_plan[k])
      drive_word(directed_plan[k].w, directed_plan[k].typed, directed_plan[k].res);
    drain();

    // random phases, each with its own geometry and idling mix
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_BLOCK_SIZE, 32'(PHASE_BLOCK[p]));
      write_reg(REG_BLOCK_ALIGN, 32'(PHASE_ALIGN[p]));
      send_idle_pct = PHASE_SEND_IDLE[p];
      recv_stall_pct = PHASE_RECV_STALL[p];
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // long hold-off on the result side while words keep coming
        if (p == 0 && k == WORDS_PER_PHASE / 2) hold_request = HOLD_CYCLES;
        drive_word(random_word(), 1'b0, NO_RES);
      end
      drain();
    end
    // stray results would show up here
    repeat (300) @(posedge clk);

    $display("ran %0d allocates (%0d granted), %0d frees, %0d regions carving %0d blocks",
             n_alloc, n_granted, n_free, n_regions, n_carved);
    $display("over %0d geometries: %0d store-full refusals, %0d bad requests, %0d mismatches",
             PHASES + 1, n_full, n_bad, errors);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_ctrl.sv
hw/rtl/fbfl_dpath.sv
hw/rtl/fixed_block_free_list_allocator.sv
tb/fixed_block_free_list_allocator_test.sv
